>>> hw/rtl/b2da_pkg.sv
package b2da_pkg;

  localparam int VALUE_W   = 32;
  localparam int MODE_W    = 2;
  localparam int CHAR_W    = 6;
  localparam int NDIG_MAX  = 10;
  localparam int DIG_W     = 4;
  localparam int DIG_IDX_W = 4;
  localparam int BIT_CNT_W = 5;

  localparam logic [MODE_W-1:0] MODE_8  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_16 = 2'd1;

  localparam logic [DIG_IDX_W-1:0] NDIG_8  = 4'd3;
  localparam logic [DIG_IDX_W-1:0] NDIG_16 = 4'd5;
  localparam logic [DIG_IDX_W-1:0] NDIG_32 = 4'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef logic [NDIG_MAX-1:0][DIG_W-1:0] bcd_t;

  typedef struct packed {
    logic                 load;
    logic                 shift;
    logic                 emit;
    logic [DIG_IDX_W-1:0] idx;
    logic                 last;
  } cmd_t;

endpackage

>>> hw/rtl/binary_to_decimal_ascii.sv
// Channel  Dir  tdata                                    tuser  tlast
// s_       in   [31:0] value, [33:32] width_mode          -      -
// m_       out  [5:0] digit_char                         -      last_digit
//
// One transaction in: an accept, 32 shift/add-3 steps, then one output beat
// per digit (3, 5 or 10 digits), most significant digit first.
// The 32-step double-dabble runs in every mode; one item is worked at a time.
// Output digit sits in a register, so m_tready low only stalls the digit run.
// rst is synchronous, active high; no pending run survives it.
module binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] value, [33:32] width_mode, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [5:0] digit_char, rest zero
  output logic        m_tlast
);

  b2da_pkg::cmd_t                 cmd;
  logic [b2da_pkg::CHAR_W-1:0]    digit_char;

  b2da_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .width_mode (s_tdata[33:32]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cmd        (cmd)
  );

  b2da_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .value      (s_tdata[31:0]),
    .width_mode (s_tdata[33:32]),
    .digit_char (digit_char),
    .last_digit (m_tlast)
  );

  assign m_tdata = {2'b00, digit_char};

endmodule

>>> hw/rtl/b2da_dp.sv
module b2da_dp (
  input  logic                                clk,
  input  b2da_pkg::cmd_t                      cmd,
  input  logic [b2da_pkg::VALUE_W-1:0]        value,
  input  logic [b2da_pkg::MODE_W-1:0]         width_mode,
  output logic [b2da_pkg::CHAR_W-1:0]         digit_char,
  output logic                                last_digit
);

  logic [b2da_pkg::VALUE_W-1:0] bin;
  b2da_pkg::bcd_t               bcd;
  b2da_pkg::bcd_t               adj;
  logic [b2da_pkg::VALUE_W-1:0] masked;
  logic [b2da_pkg::NDIG_MAX*b2da_pkg::DIG_W+b2da_pkg::VALUE_W-1:0] joined;

  always_comb begin
    case (width_mode)
      b2da_pkg::MODE_8:  masked = {24'd0, value[7:0]};
      b2da_pkg::MODE_16: masked = {16'd0, value[15:0]};
      default:           masked = value;
    endcase
  end

  // add-3 correction on every BCD digit, then one-bit shift
  always_comb begin
    for (int i = 0; i < b2da_pkg::NDIG_MAX; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    joined = {adj, bin};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= masked;
      bcd <= '0;
    end else if (cmd.shift) begin
      bcd <= joined[b2da_pkg::NDIG_MAX*b2da_pkg::DIG_W+b2da_pkg::VALUE_W-2:
                    b2da_pkg::VALUE_W-1];
      bin <= {joined[b2da_pkg::VALUE_W-2:0], 1'b0};
    end
    if (cmd.emit) begin
      digit_char <= b2da_pkg::ASCII_ZERO + {2'b00, bcd[cmd.idx]};
      last_digit <= cmd.last;
    end
  end

endmodule

>>> hw/rtl/b2da_ctrl.sv
module b2da_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [b2da_pkg::MODE_W-1:0]   width_mode,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output b2da_pkg::cmd_t                cmd
);

  typedef enum logic [1:0] {IDLE, CONV, EMIT} state_t;

  state_t                              state;
  logic [b2da_pkg::BIT_CNT_W-1:0]      bit_cnt;
  logic [b2da_pkg::DIG_IDX_W-1:0]      dig_cnt;
  logic [b2da_pkg::DIG_IDX_W-1:0]      ndig;
  logic                                accept;
  logic                                out_free;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (width_mode)
      b2da_pkg::MODE_8:  ndig = b2da_pkg::NDIG_8;
      b2da_pkg::MODE_16: ndig = b2da_pkg::NDIG_16;
      default:           ndig = b2da_pkg::NDIG_32;
    endcase
  end

  always_comb begin
    cmd.load  = accept;
    cmd.shift = (state == CONV);
    cmd.emit  = (state == EMIT) && out_free;
    cmd.idx   = dig_cnt;
    cmd.last  = (dig_cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      bit_cnt  <= '0;
      dig_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            bit_cnt <= '0;
            dig_cnt <= ndig - 4'd1;
            state   <= CONV;
          end
        end
        CONV: begin
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_W - 1)) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (cmd.emit) begin
            if (cmd.last) begin
              state <= IDLE;
            end else begin
              dig_cnt <= dig_cnt - 4'd1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == CONV) && (bit_cnt == '0))
    else $error("accept did not start conversion");

  a_conv_len: assert property (@(posedge clk) disable iff (rst)
    (state == CONV) && (bit_cnt == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_W - 1)) |=>
    (state == EMIT))
    else $error("conversion length wrong");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("emitted digit not presented");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.last |=> (state == IDLE))
    else $error("run did not end after last digit");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT) |-> (dig_cnt < b2da_pkg::NDIG_32))
    else $error("digit index out of range");
`endif

endmodule
